// ===== hdl/lru_pkg.sv =====
// Shared types and constants for the LRU page replacement block.
// Used by lru_cell and lru_page_replacement_core; depends on nothing.
package lru_pkg;

    localparam int MAX_FRAMES = 16;
    localparam int PAGE_BITS  = 16;
    localparam int IDX_W      = $clog2(MAX_FRAMES);
    localparam int RANK_W     = IDX_W;
    localparam int OLD_W      = RANK_W + 1;
    localparam int CFG_W      = 5;
    localparam int SLOT_W     = 4;
    localparam int CNT_W      = 32;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 40;

    localparam logic [CFG_W-1:0] CFG_RESET  = CFG_W'(4);
    localparam logic             KIND_REF   = 1'b0;
    localparam logic             KIND_CLEAR = 1'b1;

    typedef logic [PAGE_BITS-1:0] t_page;
    typedef logic [RANK_W-1:0]    t_rank;
    typedef logic [OLD_W-1:0]     t_old;

    // Priority flags rippling from frame 0 upward.
    typedef struct packed {
        logic hit_seen;
        logic empty_seen;
        logic lru_seen;
    } t_chain;

    // Per-frame winners of the three searches.
    typedef struct packed {
        logic hit;
        logic empty;
        logic lru;
    } t_pick;

endpackage

// ===== hdl/lru_cell.sv =====
// One page frame: stored page, valid bit and recency rank, plus its share
// of the hit, empty and LRU searches. Depends on lru_pkg.
module lru_cell (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_upd,
    input  logic                                     i_clear,
    input  lru_pkg::t_page                           i_page,
    input  logic                                     i_active,
    input  logic [lru_pkg::MAX_FRAMES-1:0]           i_act_mask,
    input  lru_pkg::t_rank [lru_pkg::MAX_FRAMES-1:0] i_ranks,
    input  lru_pkg::t_chain                          i_chain,
    output lru_pkg::t_chain                          o_chain,
    output lru_pkg::t_pick                           o_pick,
    input  logic                                     i_sel,
    input  lru_pkg::t_old                            i_old,
    output lru_pkg::t_rank                           o_rank,
    output lru_pkg::t_old                            o_old
);
    import lru_pkg::*;

    t_page r_page;
    logic  r_valid;
    t_rank r_rank;

    logic  hit_here;
    logic  empty_here;
    logic  lru_here;

    assign hit_here   = i_active && r_valid && (r_page == i_page);
    assign empty_here = i_active && !r_valid;

    // The LRU frame is the active frame whose rank no other active frame exceeds.
    always_comb begin
        lru_here = i_active;
        for (int k = 0; k < MAX_FRAMES; k++) begin
            if (i_act_mask[k] && (i_ranks[k] > r_rank)) begin
                lru_here = 1'b0;
            end
        end
    end

    assign o_pick.hit   = hit_here && !i_chain.hit_seen;
    assign o_pick.empty = empty_here && !i_chain.empty_seen;
    assign o_pick.lru   = lru_here && !i_chain.lru_seen;

    assign o_chain.hit_seen   = i_chain.hit_seen | hit_here;
    assign o_chain.empty_seen = i_chain.empty_seen | empty_here;
    assign o_chain.lru_seen   = i_chain.lru_seen | lru_here;

    assign o_rank = r_rank;
    assign o_old  = r_valid ? {1'b0, r_rank} : OLD_W'(MAX_FRAMES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else if (i_upd) begin
            if (i_sel) begin
                r_valid <= 1'b1;
                r_rank  <= '0;
            end else if (r_valid && ({1'b0, r_rank} < i_old)) begin
                r_rank <= r_rank + RANK_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd && i_sel) begin
            r_page <= i_page;
        end
    end

endmodule

// ===== hdl/lru_page_replacement_core.sv =====
// Top level of the LRU page replacement block: stream ports, frame cells,
// slot selection, fault counter and output register. Depends on lru_pkg, lru_cell.
//
// Usage:
// Each request on the slave stream carries a page number in s_tdata and a kind
// in s_tuser (0 = page reference, 1 = clear). Every request yields exactly one
// result on the master stream: m_tuser is the hit flag, m_tdata carries the
// frame slot and the saturating fault count since the last clear.
// A request is looked up and the frame row updated in the cycle it is taken;
// its result appears in the output register on the next cycle, and while the
// receiver does not stall the block takes one request per cycle. That rate is
// set by the update of the row of frame cells as a request is taken, where each
// frame compares its page and rank and the priority chains ripple from frame 0 upward.
// When the receiver stalls, the held result blocks new requests until it is
// taken; a request is accepted in the same cycle the old result leaves.
// i_cfg_we writes frames_in_use (values 0 act as 1, above 16 as 16); write it
// only while no request is outstanding.
// Synchronous reset empties all frames, zeroes the fault count, drops any held
// result and sets frames_in_use to 4. No clearing pass is needed.
module lru_page_replacement_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lru_pkg::CFG_W-1:0]         i_cfg_wdata,  // frames_in_use
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lru_pkg::IN_DATA_W-1:0]     s_tdata,      // page
    input  logic                              s_tuser,      // kind
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lru_pkg::OUT_DATA_W-1:0]    m_tdata,      // slot, fault_count, zero pad
    output logic                              m_tuser       // hit
);
    import lru_pkg::*;

    logic [CFG_W-1:0] r_frames;
    logic [CFG_W-1:0] n_active;

    logic             accept;
    logic             upd;
    logic             clr;

    logic [MAX_FRAMES-1:0] act_mask;
    t_rank [MAX_FRAMES-1:0] ranks;
    t_old  [MAX_FRAMES-1:0] olds;
    t_pick [MAX_FRAMES-1:0] picks;
    t_chain [MAX_FRAMES:0]  chain;
    logic [MAX_FRAMES-1:0]  sel;

    logic             any_hit;
    logic             any_empty;
    logic [IDX_W-1:0] sel_idx;
    t_old             sel_old;

    logic [CNT_W-1:0] r_faults;
    logic [CNT_W-1:0] n_faults;

    logic              r_m_valid;
    logic              r_hit;
    logic [SLOT_W-1:0] r_slot;
    logic [CNT_W-1:0]  r_cnt;

    assign s_tready = !r_m_valid || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign upd      = accept && (s_tuser == KIND_REF);
    assign clr      = accept && (s_tuser == KIND_CLEAR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_frames <= i_cfg_wdata;
        end
    end

    always_comb begin
        if (r_frames == '0) begin
            n_active = CFG_W'(1);
        end else if (r_frames > CFG_W'(MAX_FRAMES)) begin
            n_active = CFG_W'(MAX_FRAMES);
        end else begin
            n_active = r_frames;
        end
        for (int j = 0; j < MAX_FRAMES; j++) begin
            act_mask[j] = CFG_W'(j) < n_active;
        end
    end

    assign chain[0] = '0;

    genvar g;
    generate
        for (g = 0; g < MAX_FRAMES; g++) begin : g_cell
            lru_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_upd      (upd),
                .i_clear    (clr),
                .i_page     (s_tdata[PAGE_BITS-1:0]),
                .i_active   (act_mask[g]),
                .i_act_mask (act_mask),
                .i_ranks    (ranks),
                .i_chain    (chain[g]),
                .o_chain    (chain[g+1]),
                .o_pick     (picks[g]),
                .i_sel      (sel[g]),
                .i_old      (sel_old),
                .o_rank     (ranks[g]),
                .o_old      (olds[g])
            );
        end
    endgenerate

    assign any_hit   = chain[MAX_FRAMES].hit_seen;
    assign any_empty = chain[MAX_FRAMES].empty_seen;

    // A hit wins over an empty frame, which wins over the LRU frame.
    always_comb begin
        sel_idx = '0;
        sel_old = '0;
        for (int j = 0; j < MAX_FRAMES; j++) begin
            if (any_hit) begin
                sel[j] = picks[j].hit;
            end else if (any_empty) begin
                sel[j] = picks[j].empty;
            end else begin
                sel[j] = picks[j].lru;
            end
            if (sel[j]) begin
                sel_idx = sel_idx | IDX_W'(j);
                sel_old = sel_old | olds[j];
            end
        end
    end

    always_comb begin
        n_faults = r_faults;
        if (!any_hit && (r_faults != '1)) begin
            n_faults = r_faults + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clr) begin
            r_faults <= '0;
        end else if (upd) begin
            r_faults <= n_faults;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (accept) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (clr) begin
            r_hit  <= 1'b0;
            r_slot <= '0;
            r_cnt  <= '0;
        end else if (upd) begin
            r_hit  <= any_hit;
            r_slot <= SLOT_W'(sel_idx);
            r_cnt  <= n_faults;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tuser  = r_hit;
    assign m_tdata  = {(OUT_DATA_W - CNT_W - SLOT_W)'(0), r_cnt, r_slot};

endmodule
